@@ rtl/swmf_pkg.sv @@
// Package for the sliding window median filter: sizes, bus widths,
// the per-cell control struct and the width legalising function.
// No dependencies; every other file of the block imports it.
package swmf_pkg;

    // Window and field sizes.
    localparam int MAX_WIDTH   = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int TAG_BITS    = 8;
    localparam int WIDTH_W     = 4;
    localparam int AGE_W       = 4;

    // Slot index and rank both count up to MAX_WIDTH - 1.
    localparam int IDX_W  = $clog2(MAX_WIDTH);
    localparam int RANK_W = IDX_W;
    // Common width when slot indexes meet the window width.
    localparam int CMP_W  = (IDX_W > WIDTH_W) ? IDX_W : WIDTH_W;

    // Stream beat widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((SAMPLE_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SAMPLE_BITS + TAG_BITS + AGE_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam logic REG_WIDTH = 1'b0;

    // Largest odd width that fits in the window.
    localparam int MAX_ODD = ((MAX_WIDTH % 2) == 1) ? MAX_WIDTH : MAX_WIDTH - 1;

    // Broadcast controls for the row of cells.
    typedef struct packed {
        logic clear;
        logic write;
        logic load;
        logic step;
    } t_cell_ctrl;

    // Forces a written width odd and no larger than the window.
    function automatic logic [WIDTH_W-1:0] legal_width(input logic [WIDTH_W-1:0] value);
        logic [WIDTH_W-1:0] odd;
        odd = value | WIDTH_W'(1);
        if (int'(odd) > MAX_WIDTH) begin
            return WIDTH_W'(MAX_ODD);
        end
        return odd;
    endfunction

endpackage

@@ rtl/sliding_window_median_filter_unit.sv @@
// Sliding window median filter: top level with sequencer, ring of cells and APB port.
// A beat passes through a load state, a rank state in which the comparand walks the ring,
// and a pick state that loads the median into the output register; the pick waits for it to be free.
// A new beat is taken only in the idle state, so the block takes none while one is in flight.
// Reset (synchronous, active low): width 5, all slots and tags zero, write slot zero.
// Depends on swmf_pkg and swmf_cell.
module sliding_window_median_filter_unit import swmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream: [15:0] sample, [23:16] sample_tag.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Output stream: [15:0] median, [23:16] median_tag, [27:24] median_age.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RANK = 2'd2;
    localparam logic [1:0] ST_PICK = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_step, n_step;
    logic [WIDTH_W-1:0]    r_width;
    logic [IDX_W-1:0]      r_wr_slot;
    logic [IDX_W-1:0]      r_cur_slot;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic       s_accept;
    logic       cfg_wr;
    logic       out_free;
    t_cell_ctrl ctrl;

    logic [SAMPLE_BITS-1:0] in_sample;
    logic [TAG_BITS-1:0]    in_tag;
    logic [IDX_W:0]         slot_inc;

    logic [SAMPLE_BITS-1:0] w_val     [MAX_WIDTH];
    logic [TAG_BITS-1:0]    w_tag     [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] w_cmp_val [MAX_WIDTH];
    logic [IDX_W-1:0]       w_cmp_idx [MAX_WIDTH];
    logic [RANK_W-1:0]      w_rank    [MAX_WIDTH];

    logic [SAMPLE_BITS-1:0] med_val;
    logic [TAG_BITS-1:0]    med_tag;
    logic [IDX_W-1:0]       med_idx;
    logic [CMP_W:0]         age_full;
    logic [AGE_W-1:0]       med_age;

    // Handshakes.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == REG_WIDTH);
    assign out_free      = !r_out_valid || m_axis_tready;

    assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_tag    = s_axis_tdata[SAMPLE_BITS +: TAG_BITS];

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WIDTH) begin
            prdata = APB_DATA_W'(r_width);
        end
    end

    // Controls broadcast to every cell.
    always_comb begin
        ctrl.clear = cfg_wr;
        ctrl.write = s_accept;
        ctrl.load  = (r_state == ST_LOAD);
        ctrl.step  = (r_state == ST_RANK);
    end

    // Ring of cells; each takes its comparand from the cell below it.
    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        localparam int NB = (k == 0) ? MAX_WIDTH - 1 : k - 1;
        swmf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_index      (IDX_W'(k)),
            .i_width      (r_width),
            .i_wr_sel     (r_wr_slot == IDX_W'(k)),
            .i_sample     (in_sample),
            .i_tag        (in_tag),
            .i_nb_val     (w_val[NB]),
            .i_nb_cmp_val (w_cmp_val[NB]),
            .i_nb_cmp_idx (w_cmp_idx[NB]),
            .o_val        (w_val[k]),
            .o_tag        (w_tag[k]),
            .o_cmp_val    (w_cmp_val[k]),
            .o_cmp_idx    (w_cmp_idx[k]),
            .o_rank       (w_rank[k])
        );
    end

    // The median is the one active slot whose rank is half the width.
    always_comb begin
        med_val = '0;
        med_tag = '0;
        med_idx = '0;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            if ((CMP_W'(k) < CMP_W'(r_width)) &&
                (CMP_W'(w_rank[k]) == CMP_W'(r_width >> 1))) begin
                med_val = med_val | w_val[k];
                med_tag = med_tag | w_tag[k];
                med_idx = med_idx | IDX_W'(k);
            end
        end
    end

    // Age of the median, counted back from the slot just written.
    always_comb begin
        if (r_cur_slot >= med_idx) begin
            age_full = (CMP_W+1)'(r_cur_slot) - (CMP_W+1)'(med_idx);
        end else begin
            age_full = (CMP_W+1)'(r_cur_slot) + (CMP_W+1)'(r_width) - (CMP_W+1)'(med_idx);
        end
        med_age = age_full[AGE_W-1:0];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_step  = '0;
                n_state = ST_RANK;
            end
            ST_RANK: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == IDX_W'(MAX_WIDTH - 2)) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Width register and write pointer.
    assign slot_inc = (IDX_W+1)'(r_wr_slot) + (IDX_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= legal_width(WIDTH_W'(5));
            r_wr_slot <= '0;
        end else if (cfg_wr) begin
            r_width   <= legal_width(pwdata[WIDTH_W-1:0]);
            r_wr_slot <= '0;
        end else if (s_accept) begin
            if (CMP_W'(slot_inc) >= CMP_W'(r_width)) begin
                r_wr_slot <= '0;
            end else begin
                r_wr_slot <= slot_inc[IDX_W-1:0];
            end
        end
    end

    // Slot written by the beat in flight.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cur_slot <= r_wr_slot;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PICK) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PICK) && out_free) begin
            r_out_data <= OUT_DATA_W'({med_age, med_tag, med_val});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/swmf_cell.sv @@
// One window slot of the median filter: holds a sample and its tag, and
// ranks it against a comparand that walks along the ring of cells.
// Depends on swmf_pkg.
module swmf_cell import swmf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [IDX_W-1:0]       i_index,
    input  logic [WIDTH_W-1:0]     i_width,
    input  logic                   i_wr_sel,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TAG_BITS-1:0]    i_tag,
    input  logic [SAMPLE_BITS-1:0] i_nb_val,
    input  logic [SAMPLE_BITS-1:0] i_nb_cmp_val,
    input  logic [IDX_W-1:0]       i_nb_cmp_idx,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic [TAG_BITS-1:0]    o_tag,
    output logic [SAMPLE_BITS-1:0] o_cmp_val,
    output logic [IDX_W-1:0]       o_cmp_idx,
    output logic [RANK_W-1:0]      o_rank
);

    logic [SAMPLE_BITS-1:0] r_val;
    logic [TAG_BITS-1:0]    r_tag;
    logic [SAMPLE_BITS-1:0] r_cmp_val;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic [RANK_W-1:0]      r_rank;

    logic [IDX_W-1:0] prev_idx;
    logic             own_active;
    logic             cmp_active;
    logic             point;

    // Index of the neighbour that feeds this cell around the ring.
    assign prev_idx = (i_index == '0) ? IDX_W'(MAX_WIDTH - 1) : i_index - IDX_W'(1);

    // Only slots inside the current window take part.
    assign own_active = CMP_W'(i_index) < CMP_W'(i_width);
    assign cmp_active = CMP_W'(r_cmp_idx) < CMP_W'(i_width);

    // Ties rank the lower slot above the higher one.
    assign point = own_active && cmp_active &&
                   (((r_cmp_idx > i_index) && ($signed(r_val) >= $signed(r_cmp_val))) ||
                    ((r_cmp_idx < i_index) && ($signed(r_val) >  $signed(r_cmp_val))));

    // Stored sample and tag; a width write clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_val <= '0;
            r_tag <= '0;
        end else if (i_ctrl.write && i_wr_sel) begin
            r_val <= i_sample;
            r_tag <= i_tag;
        end
    end

    // Comparand shift and rank accumulation.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmp_val <= i_nb_val;
            r_cmp_idx <= prev_idx;
            r_rank    <= '0;
        end else if (i_ctrl.step) begin
            r_cmp_val <= i_nb_cmp_val;
            r_cmp_idx <= i_nb_cmp_idx;
            r_rank    <= r_rank + RANK_W'(point);
        end
    end

    assign o_val     = r_val;
    assign o_tag     = r_tag;
    assign o_cmp_val = r_cmp_val;
    assign o_cmp_idx = r_cmp_idx;
    assign o_rank    = r_rank;

endmodule
